// ----- src/hkc_pkg.sv -----
`default_nettype none

package hkc_pkg;

    // Default size of the key map.
    localparam int KEY_COUNT_DEFAULT = 768;

    // Field widths fixed by the interface.
    localparam int KEY_CODE_W = 10;
    localparam int HOTKEY_W   = 11;
    localparam int PERIOD_W   = 37;
    localparam int CFG_DATA_W = 37;
    localparam int CFG_IDX_W  = 3;

    // Register reset values.
    localparam logic [HOTKEY_W-1:0] HOTKEY_UNUSED  = 11'h7FF;
    localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 37'd1000000;

    // Keys whose right-hand twin also drives them.
    localparam logic [KEY_CODE_W-1:0] CODE_LEFTCTRL   = 10'd29;
    localparam logic [KEY_CODE_W-1:0] CODE_LEFTSHIFT  = 10'd42;
    localparam logic [KEY_CODE_W-1:0] CODE_RIGHTSHIFT = 10'd54;
    localparam logic [KEY_CODE_W-1:0] CODE_LEFTALT    = 10'd56;
    localparam logic [KEY_CODE_W-1:0] CODE_RIGHTCTRL  = 10'd97;
    localparam logic [KEY_CODE_W-1:0] CODE_RIGHTALT   = 10'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOTKEY_A = 3'd0,
        CFG_HOTKEY_B = 3'd1,
        CFG_HOTKEY_C = 3'd2,
        CFG_BUTTON   = 3'd3,
        CFG_PERIOD   = 3'd4
    } cfg_index_t;

    typedef enum logic {
        ITEM_KEY  = 1'b0,
        ITEM_TICK = 1'b1
    } item_kind_t;

    typedef enum logic [2:0] {
        EV_PRESS   = 3'd0,
        EV_SYNC    = 3'd1,
        EV_RELEASE = 3'd2,
        EV_STARTED = 3'd3,
        EV_STOPPED = 3'd4
    } event_kind_t;

    typedef struct packed {
        item_kind_t              kind;
        logic [KEY_CODE_W-1:0]   key_code;
        logic [1:0]              key_value;
    } item_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic        button_sel;
        logic        last_of_run;
    } result_t;

endpackage

`default_nettype wire

// ----- src/hkc_ram.sv -----
`default_nettype none

module hkc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/hotkey_toggled_click_generator.sv -----
// Hotkey-toggled click generator. Items on the item channel are key events or
// time ticks; an item lands in an input register and is processed from there,
// so one item can be taken every cycle while the result register has room. A
// chord that completes gives one result transaction, and a click tick gives
// four (press, sync, release, sync); a further item that gives results waits
// in the input register until all of them have been taken. After reset the key
// map memory is cleared at one entry per cycle, which keeps the item channel
// stalled until every entry is cleared. A write to any of the three hotkey
// registers stalls the item channel from the write cycle on, while the held
// state of the new key is fetched from the key map memory; hotkey writes in a
// row are fetched in turn, so the stall ends once the last of them has been
// fetched (or after the clearing pass, if that is still running). Any other
// register write stalls only its own cycle.
`default_nettype none

module hotkey_toggled_click_generator #(
    parameter int KEY_COUNT = hkc_pkg::KEY_COUNT_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire hkc_pkg::item_t                    item,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output hkc_pkg::result_t                       result,
    input  wire logic                              cfg_we,
    input  wire logic [hkc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hkc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import hkc_pkg::*;

    localparam int AW = $clog2(KEY_COUNT);
    localparam logic [HOTKEY_W-1:0] KEY_LIMIT = HOTKEY_W'(KEY_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_COUNT - 1);

    // True when a hotkey code is also set by a right-hand twin key.
    function automatic logic is_special(input logic [HOTKEY_W-1:0] hk);
        is_special = (hk == {1'b0, CODE_LEFTCTRL}) || (hk == {1'b0, CODE_LEFTSHIFT}) ||
                     (hk == {1'b0, CODE_LEFTALT});
    endfunction

    // Held state of a twin-driven left key, zero for any other code.
    function automatic logic special_bit(input logic [HOTKEY_W-1:0] hk,
                                         input logic lctrl, input logic lshift,
                                         input logic lalt);
        logic b;
        b = 1'b0;
        if (hk == {1'b0, CODE_LEFTCTRL})
        begin
            b = lctrl;
        end
        else if (hk == {1'b0, CODE_LEFTSHIFT})
        begin
            b = lshift;
        end
        else if (hk == {1'b0, CODE_LEFTALT})
        begin
            b = lalt;
        end
        special_bit = b;
    endfunction

    // True when a key event with this code changes the state of hotkey hk.
    function automatic logic key_hits(input logic [HOTKEY_W-1:0] hk,
                                      input logic [KEY_CODE_W-1:0] code);
        key_hits = (hk == {1'b0, code}) ||
                   ((hk == {1'b0, CODE_LEFTCTRL}) && (code == CODE_RIGHTCTRL)) ||
                   ((hk == {1'b0, CODE_LEFTSHIFT}) && (code == CODE_RIGHTSHIFT)) ||
                   ((hk == {1'b0, CODE_LEFTALT}) && (code == CODE_RIGHTALT));
    endfunction

    // Configuration registers.
    logic [2:0][HOTKEY_W-1:0] hk_reg, hk_next;
    logic                     button_reg, button_next;
    logic [PERIOD_W-1:0]      period_reg, period_next;

    // Block state.
    logic [2:0]          shadow_reg, shadow_next;
    logic                lctrl_reg, lctrl_next;
    logic                lshift_reg, lshift_next;
    logic                lalt_reg, lalt_next;
    logic                was_reg, was_next;
    logic                running_reg, running_next;
    logic                armed_reg, armed_next;
    logic [PERIOD_W-1:0] ttn_reg, ttn_next;

    // Key map clearing pass.
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Hotkey refresh after a hotkey register write.
    logic [2:0] pend_reg, pend_next;
    logic       rf_inflight_reg, rf_inflight_next;
    logic [1:0] rf_idx_reg, rf_idx_next;

    // Input register.
    logic  in_full_reg, in_full_next;
    item_t in_item_reg, in_item_next;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic       burst_click_reg, burst_click_next;
    logic       burst_btn_reg, burst_btn_next;
    logic       burst_start_reg, burst_start_next;
    logic [1:0] beat_reg, beat_next;

    // Combinational signals.
    logic [2:0]          cfg_hk_wr;
    logic [2:0]          hk_unused, hk_in_range, key_match, shadow_upd;
    logic                code_in_range, held, is_key, key_evt, chord, toggle;
    logic [PERIOD_W-1:0] cnt_eff;
    logic                click, has_result, drain, load;
    logic                out_accept, out_last, burst_free, item_accept;
    logic                rf_issue, rf_busy;
    logic [1:0]          rf_sel;
    logic [2:0]          rf_sel_onehot;
    logic                ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0]       ram_waddr, ram_raddr;

    // Hotkey register writes by index.
    always_comb
    begin
        cfg_hk_wr[0] = cfg_we && (cfg_index == CFG_HOTKEY_A);
        cfg_hk_wr[1] = cfg_we && (cfg_index == CFG_HOTKEY_B);
        cfg_hk_wr[2] = cfg_we && (cfg_index == CFG_HOTKEY_C);
    end

    // Key event decode and chord check on the updated hotkey state.
    always_comb
    begin
        is_key        = (in_item_reg.kind == ITEM_KEY);
        code_in_range = ({1'b0, in_item_reg.key_code} < KEY_LIMIT);
        held          = |in_item_reg.key_value;
        key_evt       = is_key && code_in_range;
        for (int i = 0; i < 3; i++)
        begin
            hk_unused[i]   = (hk_reg[i] == HOTKEY_UNUSED);
            hk_in_range[i] = !hk_reg[i][HOTKEY_W-1] && (hk_reg[i] < KEY_LIMIT);
            key_match[i]   = hk_in_range[i] && key_hits(hk_reg[i], in_item_reg.key_code);
            shadow_upd[i]  = (key_evt && key_match[i]) ? held : shadow_reg[i];
        end
        chord  = &(hk_unused | (hk_in_range & shadow_upd));
        toggle = key_evt && chord && !was_reg;
    end

    // Tick decode: a running tick clicks when the countdown has reached zero.
    always_comb
    begin
        cnt_eff    = armed_reg ? ttn_reg : '0;
        click      = !is_key && running_reg && (cnt_eff == '0);
        has_result = toggle || click;
    end

    // Handshakes between the input register and the result register.
    always_comb
    begin
        out_accept  = out_valid_reg && !result_stall;
        out_last    = !burst_click_reg || (beat_reg == 2'd3);
        burst_free  = !out_valid_reg || (out_accept && out_last);
        drain       = in_full_reg && (burst_free || !has_result);
        load        = drain && has_result;
        rf_busy     = (|pend_reg) || rf_inflight_reg;
        item_stall  = clearing_reg || rf_busy || cfg_we || (in_full_reg && !drain);
        item_accept = item_valid && !item_stall;
    end

    // Refresh request selection, lowest pending hotkey first.
    always_comb
    begin
        rf_sel        = 2'd0;
        rf_sel_onehot = 3'b001;
        if (!pend_reg[0] && pend_reg[1])
        begin
            rf_sel        = 2'd1;
            rf_sel_onehot = 3'b010;
        end
        else if (!pend_reg[0] && !pend_reg[1])
        begin
            rf_sel        = 2'd2;
            rf_sel_onehot = 3'b100;
        end
        rf_issue  = !clearing_reg && !in_full_reg && (|pend_reg);
        ram_raddr = hk_reg[rf_sel][AW-1:0];
    end

    // Key map memory write: clearing pass first, then key events.
    always_comb
    begin
        ram_we    = clearing_reg || (drain && key_evt);
        ram_waddr = clearing_reg ? clr_cnt_reg : in_item_reg.key_code[AW-1:0];
        ram_wdata = clearing_reg ? 1'b0 : held;
    end

    hkc_ram #(
        .WIDTH (1),
        .DEPTH (KEY_COUNT)
    ) u_key_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rf_issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration, refresh and clearing control.
    always_comb
    begin
        hk_next          = hk_reg;
        button_next      = button_reg;
        period_next      = period_reg;
        clearing_next    = clearing_reg;
        clr_cnt_next     = clr_cnt_reg;
        pend_next        = (pend_reg & ~(rf_issue ? rf_sel_onehot : 3'b000)) | cfg_hk_wr;
        rf_inflight_next = rf_issue && !cfg_hk_wr[rf_sel];
        rf_idx_next      = rf_issue ? rf_sel : rf_idx_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOTKEY_A: hk_next[0]  = cfg_data[HOTKEY_W-1:0];
                CFG_HOTKEY_B: hk_next[1]  = cfg_data[HOTKEY_W-1:0];
                CFG_HOTKEY_C: hk_next[2]  = cfg_data[HOTKEY_W-1:0];
                CFG_BUTTON:   button_next = cfg_data[0];
                CFG_PERIOD:   period_next = cfg_data[PERIOD_W-1:0];
                default:      ;
            endcase
        end

        if (clearing_reg)
        begin
            if (clr_cnt_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    // Key, chord, run and countdown state.
    always_comb
    begin
        shadow_next  = shadow_reg;
        lctrl_next   = lctrl_reg;
        lshift_next  = lshift_reg;
        lalt_next    = lalt_reg;
        was_next     = was_reg;
        running_next = running_reg;
        armed_next   = armed_reg;
        ttn_next     = ttn_reg;

        if (drain && key_evt)
        begin
            shadow_next = shadow_upd;
            if ((in_item_reg.key_code == CODE_LEFTCTRL) ||
                (in_item_reg.key_code == CODE_RIGHTCTRL))
            begin
                lctrl_next = held;
            end
            if ((in_item_reg.key_code == CODE_LEFTSHIFT) ||
                (in_item_reg.key_code == CODE_RIGHTSHIFT))
            begin
                lshift_next = held;
            end
            if ((in_item_reg.key_code == CODE_LEFTALT) ||
                (in_item_reg.key_code == CODE_RIGHTALT))
            begin
                lalt_next = held;
            end
            if (toggle)
            begin
                running_next = !running_reg;
                was_next     = 1'b1;
            end
            else if (!chord)
            begin
                was_next = 1'b0;
            end
        end

        if (drain && !is_key)
        begin
            if (!running_reg)
            begin
                armed_next = 1'b0;
            end
            else
            begin
                armed_next = 1'b1;
                if (cnt_eff != '0)
                begin
                    ttn_next = cnt_eff - 1'b1;
                end
                else
                begin
                    ttn_next = (period_reg == '0) ? '0 : period_reg - 1'b1;
                end
            end
        end

        // A fetched key map bit lands unless its hotkey was rewritten meanwhile.
        if (rf_inflight_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if ((rf_idx_reg == 2'(i)) && !cfg_hk_wr[i])
                begin
                    shadow_next[i] = is_special(hk_reg[i]) ?
                        special_bit(hk_reg[i], lctrl_reg, lshift_reg, lalt_reg) :
                        ram_rdata;
                end
            end
        end

        // A new hotkey code starts from its twin-driven value or zero.
        for (int i = 0; i < 3; i++)
        begin
            if (cfg_hk_wr[i])
            begin
                shadow_next[i] = special_bit(cfg_data[HOTKEY_W-1:0], lctrl_reg,
                                             lshift_reg, lalt_reg);
            end
        end
    end

    // Input register.
    always_comb
    begin
        in_full_next = item_accept || (in_full_reg && !drain);
        in_item_next = item_accept ? item : in_item_reg;
    end

    // Result register: one transaction for a toggle, four for a click.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        burst_click_next = burst_click_reg;
        burst_btn_next   = burst_btn_reg;
        burst_start_next = burst_start_reg;
        beat_next        = beat_reg;
        if (load)
        begin
            out_valid_next   = 1'b1;
            burst_click_next = click;
            burst_btn_next   = button_reg;
            burst_start_next = !running_reg;
            beat_next        = 2'd0;
        end
        else if (out_accept)
        begin
            if (out_last)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                beat_next = beat_reg + 1'b1;
            end
        end
    end

    // Result payload.
    always_comb
    begin
        result_valid       = out_valid_reg;
        result.last_of_run = out_last;
        result.button_sel  = 1'b0;
        if (!burst_click_reg)
        begin
            result.event_kind = burst_start_reg ? EV_STARTED : EV_STOPPED;
        end
        else
        begin
            case (beat_reg)
                2'd0:
                begin
                    result.event_kind = EV_PRESS;
                    result.button_sel = burst_btn_reg;
                end
                2'd1: result.event_kind = EV_SYNC;
                2'd2:
                begin
                    result.event_kind = EV_RELEASE;
                    result.button_sel = burst_btn_reg;
                end
                default: result.event_kind = EV_SYNC;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hk_reg           <= {3{HOTKEY_UNUSED}};
            button_reg       <= 1'b0;
            period_reg       <= PERIOD_DEFAULT;
            shadow_reg       <= '0;
            lctrl_reg        <= 1'b0;
            lshift_reg       <= 1'b0;
            lalt_reg         <= 1'b0;
            was_reg          <= 1'b0;
            running_reg      <= 1'b0;
            armed_reg        <= 1'b0;
            ttn_reg          <= '0;
            clearing_reg     <= 1'b1;
            clr_cnt_reg      <= '0;
            pend_reg         <= '0;
            rf_inflight_reg  <= 1'b0;
            rf_idx_reg       <= 2'd0;
            in_full_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            burst_click_reg  <= 1'b0;
            beat_reg         <= 2'd0;
        end
        else
        begin
            hk_reg           <= hk_next;
            button_reg       <= button_next;
            period_reg       <= period_next;
            shadow_reg       <= shadow_next;
            lctrl_reg        <= lctrl_next;
            lshift_reg       <= lshift_next;
            lalt_reg         <= lalt_next;
            was_reg          <= was_next;
            running_reg      <= running_next;
            armed_reg        <= armed_next;
            ttn_reg          <= ttn_next;
            clearing_reg     <= clearing_next;
            clr_cnt_reg      <= clr_cnt_next;
            pend_reg         <= pend_next;
            rf_inflight_reg  <= rf_inflight_next;
            rf_idx_reg       <= rf_idx_next;
            in_full_reg      <= in_full_next;
            out_valid_reg    <= out_valid_next;
            burst_click_reg  <= burst_click_next;
            beat_reg         <= beat_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        in_item_reg     <= in_item_next;
        burst_btn_reg   <= burst_btn_next;
        burst_start_reg <= burst_start_next;
    end

    // The item channel stays closed while the key map is being cleared.
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> item_stall)
        else $error("item channel open during key map clearing");

    // A refresh read never overlaps a key event waiting to write the key map.
    a_refresh_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rf_inflight_reg |-> !in_full_reg)
        else $error("hotkey refresh overlaps a pending key event");

    // Run started and stopped are always single, final transactions.
    a_toggle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ((result.event_kind == EV_STARTED) ||
                          (result.event_kind == EV_STOPPED))) |-> result.last_of_run)
        else $error("run toggle result not marked last");

    // A click that is part way through keeps its remaining transactions.
    a_click_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && !out_last) |=> (result_valid && burst_click_reg))
        else $error("click burst cut short");

    // A completed chord flips the run flag.
    a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
        (drain && toggle) |=> (running_reg != $past(running_reg)))
        else $error("chord completed without toggling the run flag");

endmodule

`default_nettype wire

// ----- sim/hotkey_toggled_click_generator_tb.sv -----
`timescale 1ns / 1ps

module hotkey_toggled_click_generator_tb;

    import hkc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int KEYS           = KEY_COUNT_DEFAULT;
    localparam int PHASE_ITEMS    = 65;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED    = 40;

    // Mirror of the click generator: key map, chord edge, run flag and click countdown.
    class click_scoreboard;
        logic [KEYS-1:0]   held;
        logic              chord_prev;
        logic              run_on;
        logic              armed;
        logic [PERIOD_W-1:0] countdown;
        logic signed [HOTKEY_W-1:0] hotkey [3];
        logic              button;
        logic [PERIOD_W-1:0] period;
        result_t           awaited_q [$];
        int                errors;

        function new();
            held       = '0;
            chord_prev = 1'b0;
            run_on     = 1'b0;
            armed      = 1'b0;
            countdown  = '0;
            hotkey[0]  = HOTKEY_UNUSED;
            hotkey[1]  = HOTKEY_UNUSED;
            hotkey[2]  = HOTKEY_UNUSED;
            button     = 1'b0;
            period     = PERIOD_DEFAULT;
            errors     = 0;
        endfunction

        function void report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t ns: mismatch: %s", $time, what);
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HOTKEY_A: hotkey[0] = data[HOTKEY_W-1:0];
                CFG_HOTKEY_B: hotkey[1] = data[HOTKEY_W-1:0];
                CFG_HOTKEY_C: hotkey[2] = data[HOTKEY_W-1:0];
                CFG_BUTTON:   button    = data[0];
                CFG_PERIOD:   period    = data[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        // An unused hotkey counts as held; a code outside the key map never does.
        function bit hotkey_held(logic signed [HOTKEY_W-1:0] code);
            int c;
            c = code;
            if (c == -1)
                return 1'b1;
            if (c < 0 || c >= KEYS)
                return 1'b0;
            return held[c];
        endfunction

        function void queue_event(event_kind_t kind, logic btn, logic last);
            result_t r;
            r.event_kind  = kind;
            r.button_sel  = btn;
            r.last_of_run = last;
            awaited_q.push_back(r);
        endfunction

        // Works out the results that one accepted input transaction causes.
        function void note_item(item_t it);
            logic on;
            bit   chord;
            if (it.kind == ITEM_KEY) begin
                if (it.key_code >= KEYS)
                    return;
                on = (it.key_value != 2'd0);
                held[it.key_code] = on;
                case (it.key_code)
                    CODE_RIGHTCTRL:  held[CODE_LEFTCTRL]  = on;
                    CODE_RIGHTSHIFT: held[CODE_LEFTSHIFT] = on;
                    CODE_RIGHTALT:   held[CODE_LEFTALT]   = on;
                    default: ;
                endcase
                chord = hotkey_held(hotkey[0]) && hotkey_held(hotkey[1])
                        && hotkey_held(hotkey[2]);
                if (chord && !chord_prev) begin
                    run_on     = !run_on;
                    chord_prev = 1'b1;
                    queue_event(run_on ? EV_STARTED : EV_STOPPED, 1'b0, 1'b1);
                end else if (!chord) begin
                    chord_prev = 1'b0;
                end
                return;
            end
            // A tick while stopped disarms, so the next running tick clicks at once.
            if (!run_on) begin
                armed = 1'b0;
                return;
            end
            if (!armed) begin
                armed     = 1'b1;
                countdown = '0;
            end
            if (countdown != '0) begin
                countdown = countdown - 1'b1;
                return;
            end
            countdown = (period == '0) ? '0 : period - 1'b1;
            queue_event(EV_PRESS, button, 1'b0);
            queue_event(EV_SYNC, 1'b0, 1'b0);
            queue_event(EV_RELEASE, button, 1'b0);
            queue_event(EV_SYNC, 1'b0, 1'b1);
        endfunction

        function void check_result(result_t r);
            result_t want;
            if (awaited_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result, event_kind %0d",
                                          r.event_kind));
                return;
            end
            want = awaited_q.pop_front();
            if (r.event_kind !== want.event_kind)
                report_mismatch($sformatf("event_kind got %0d want %0d",
                                          r.event_kind, want.event_kind));
            if (r.button_sel !== want.button_sel)
                report_mismatch($sformatf("button_sel got %0b want %0b (event %0d)",
                                          r.button_sel, want.button_sel, want.event_kind));
            if (r.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run got %0b want %0b (event %0d)",
                                          r.last_of_run, want.last_of_run, want.event_kind));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic calm = 1'b0;
    logic hold_go = 1'b0;
    int   hold_count = 0;
    int   quiet_cycles = 0;

    click_scoreboard sb;

    hotkey_toggled_click_generator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Result side: check each accepted transaction, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (hold_go && hold_count < HOLD_CYCLES) begin
            result_stall <= 1'b1;
            hold_count   <= hold_count + 1;
        end else begin
            result_stall <= !calm && ($urandom_range(0, 99) < 33);
        end
    end

    // Watchdog: ends the run when nothing has moved on either channel for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic item_t key_item(int code, int value);
        item_t it;
        it.kind      = ITEM_KEY;
        it.key_code  = code[KEY_CODE_W-1:0];
        it.key_value = value[1:0];
        return it;
    endfunction

    // Tick fields other than the kind are don't-care, so they carry noise.
    function automatic item_t tick_item();
        item_t it;
        it.kind      = ITEM_TICK;
        it.key_code  = KEY_CODE_W'($urandom);
        it.key_value = 2'($urandom);
        return it;
    endfunction

    // Offers one input transaction, with random idle cycles ahead of it.
    task automatic send_item(input item_t it);
        while (!calm && $urandom_range(0, 99) < 33) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(it);
    endtask

    // Waits until every expected result is in and the last key event has settled.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Unused upper bits of the narrow registers carry noise.
    task automatic program_regs(input int a, input int b, input int c, input bit btn,
                                input logic [PERIOD_W-1:0] period);
        write_reg(CFG_HOTKEY_A, {26'($urandom), 11'(a)});
        write_reg(CFG_HOTKEY_B, {26'($urandom), 11'(b)});
        write_reg(CFG_HOTKEY_C, {26'($urandom), 11'(c)});
        write_reg(CFG_BUTTON, {36'($urandom), btn});
        write_reg(CFG_PERIOD, period);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One random phase: mostly ticks and chord keys, some other keys and some ignored codes.
    task automatic run_phase(input int a, input int b, input int c, input bit btn,
                             input logic [PERIOD_W-1:0] period,
                             input int p0, input int p1, input int p2, input int p3,
                             input int tick_pct, input bit pressure);
        int    chord_keys [4];
        int    counted;
        int    r;
        item_t it;
        chord_keys = '{p0, p1, p2, p3};
        settle();
        program_regs(a, b, c, btn, period);
        if (pressure) begin
            calm    <= 1'b1;
            hold_go <= 1'b1;
        end
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < tick_pct)
                it = tick_item();
            else if (r < tick_pct + (100 - tick_pct) * 6 / 10)
                it = key_item(chord_keys[$urandom_range(0, 3)], $urandom_range(0, 3));
            else if (r < 94)
                it = key_item($urandom_range(0, KEYS - 1), $urandom_range(0, 3));
            else
                it = key_item($urandom_range(KEYS, 1023), $urandom_range(0, 3));
            send_item(it);
            if (it.kind == ITEM_TICK || it.key_code < KEYS)
                counted++;
        end
        calm <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // With every hotkey unused the first key event starts the run.
        send_item(key_item(5, 1));
        send_item(tick_item());
        send_item(tick_item());
        send_item(key_item(768, 1));
        send_item(key_item(1023, 2));
        settle();

        // Chord of left ctrl, key 30 and the top key code; period zero acts as one.
        program_regs(CODE_LEFTCTRL, 30, KEYS - 1, 1'b1, '0);
        send_item(key_item(CODE_RIGHTCTRL, 1));
        send_item(key_item(30, 2));
        send_item(key_item(KEYS - 1, 3));
        send_item(tick_item());
        send_item(key_item(KEYS - 1, 0));
        send_item(key_item(KEYS - 1, 1));
        send_item(tick_item());
        send_item(tick_item());
        send_item(key_item(CODE_RIGHTCTRL, 0));
        send_item(key_item(CODE_LEFTCTRL, 1));
        send_item(key_item(CODE_LEFTCTRL, 0));
        send_item(key_item(CODE_LEFTCTRL, 1));
        send_item(tick_item());
        send_item(key_item(CODE_RIGHTSHIFT, 1));
        send_item(key_item(CODE_RIGHTALT, 1));
        send_item(key_item(CODE_RIGHTSHIFT, 0));
        send_item(key_item(0, 1));
        send_item(key_item(KEYS, 1));
        send_item(tick_item());

        // Random phases over several register settings.
        run_phase(CODE_LEFTSHIFT, CODE_LEFTALT, -1, 1'b0, 37'd3,
                  CODE_RIGHTSHIFT, CODE_RIGHTALT, CODE_LEFTSHIFT, CODE_LEFTALT, 40, 1'b0);
        run_phase(KEYS - 1, -1, -1, 1'b1, 37'd1,
                  KEYS - 1, KEYS - 1, 5, 6, 70, 1'b1);
        run_phase(-1024, 1023, -2, 1'b0, 37'd100000000000,
                  0, 1, 2, 3, 40, 1'b0);
        run_phase(CODE_RIGHTCTRL, CODE_LEFTCTRL, 10, 1'b1, 37'd2,
                  CODE_RIGHTCTRL, CODE_LEFTCTRL, 10, 0, 40, 1'b0);
        run_phase(3, -1, -1, 1'b0, {PERIOD_W{1'b1}},
                  3, 3, 3, 4, 45, 1'b0);
        run_phase(0, KEYS - 1, -1, 1'b1, 37'd1,
                  0, KEYS - 1, 0, KEYS - 1, 40, 1'b0);

        settle();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- hotkey_toggled_click_generator.f -----
src/hkc_pkg.sv
src/hkc_ram.sv
src/hotkey_toggled_click_generator.sv
sim/hotkey_toggled_click_generator_tb.sv
